// File: src/oaht_pkg.sv
// Package for the open-address hash table: sizes, opcodes, beat structs and
// the sequencer state type. No dependencies; used by open_address_hash_table_top.
package oaht_pkg;

    localparam int MAX_SLOTS_LOG2 = 10;
    localparam int MIN_SIZE_LOG2  = 4;
    localparam int DEPTH          = 1 << MAX_SLOTS_LOG2;
    localparam int ADDR_W         = MAX_SLOTS_LOG2;
    localparam int CNT_W          = MAX_SLOTS_LOG2 + 1;
    localparam int PROBE_STEP     = 13;
    localparam int KEY_W          = 64;
    localparam int VAL_W          = 32;
    localparam int CFG_W          = 4;

    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd10;
    localparam logic [KEY_W-1:0] EMPTY_KEY  = '1;

    typedef logic [1:0] t_op;
    localparam t_op OP_QUERY    = 2'd0;
    localparam t_op OP_REGISTER = 2'd1;
    localparam t_op OP_ERASE    = 2'd2;

    typedef struct packed {
        t_op                     op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    was_added;
        logic                    overflow;
        logic                    half_full;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CMP
    } t_state;

endpackage

// File: src/open_address_hash_table_top.sv
// Open-address hash table top level: fold hash, probe sequencer, slot memories.
// Depends on oaht_pkg for sizes, opcodes, beat structs and the state type.
//
//  channel   direction  handshake                       payload
//  command   in         start & !busy                   i_cmd    (t_cmd)
//  result    out        o_done, one cycle, no stall     o_result (t_result)
//  config    in         i_cfg_valid & o_cfg_ready       i_cfg_data (size_log2)
//
// A command folds the key one chunk at a time (up to 16 chunks), then probes
// slots; the single key memory read port is registered, so each probe passes
// through a read state and a compare state. A reserved key or an unknown op
// skips the fold and the probe. The result beat appears in the cycle after
// the last probe, and a new command may start then.
// After reset a clearing pass writes every key slot empty, one per cycle;
// busy stays high meanwhile, configuration writes are still taken.
// Configuration is held off while a command is hashing or probing.
// The receiver cannot stall, so results are never held back.
module open_address_hash_table_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  oaht_pkg::t_cmd  i_cmd,
    output logic            o_done,
    output oaht_pkg::t_result o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [oaht_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW = oaht_pkg::ADDR_W;
    localparam int CW = oaht_pkg::CNT_W;
    localparam int KW = oaht_pkg::KEY_W;
    localparam int VW = oaht_pkg::VAL_W;
    localparam int LW = oaht_pkg::CFG_W;

    // Slot memories.
    logic [KW-1:0] mem_key [oaht_pkg::DEPTH];
    logic [VW-1:0] mem_val [oaht_pkg::DEPTH];

    oaht_pkg::t_state  r_state, n_state;
    oaht_pkg::t_cmd    r_cmd, n_cmd;
    oaht_pkg::t_result r_result, n_result;
    logic              r_done, n_done;
    logic [LW-1:0]     r_size_log2;
    logic [AW-1:0]     r_clr_addr;
    logic [CW-1:0]     r_count, n_count;
    logic [KW-1:0]     r_fold_key, n_fold_key;
    logic [AW-1:0]     r_acc, n_acc;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_probes, n_probes;
    logic [KW-1:0]     r_rd_key;
    logic [VW-1:0]     r_rd_val;

    logic [LW-1:0]     lg;
    logic [CW-1:0]     n_slots;
    logic [AW-1:0]     slot_mask;
    logic [KW-1:0]     fold_mask;
    logic              accept;
    logic              bypass;
    logic              slot_empty;
    logic              slot_hit;
    logic              last_probe;
    logic              room;
    logic [CW-1:0]     probes_inc;

    logic              key_we;
    logic [AW-1:0]     key_waddr;
    logic [KW-1:0]     key_wdata;
    logic              val_we;
    logic [VW-1:0]     val_wdata;

    // Size in use, saturated into the supported range.
    always_comb begin
        if (r_size_log2 < LW'(oaht_pkg::MIN_SIZE_LOG2)) begin
            lg = LW'(oaht_pkg::MIN_SIZE_LOG2);
        end else if (r_size_log2 > LW'(oaht_pkg::MAX_SLOTS_LOG2)) begin
            lg = LW'(oaht_pkg::MAX_SLOTS_LOG2);
        end else begin
            lg = r_size_log2;
        end
    end

    assign n_slots    = CW'(1) << lg;
    assign slot_mask  = AW'(n_slots - CW'(1));
    assign fold_mask  = (KW'(1) << lg) - KW'(1);
    assign accept     = start && !busy;
    assign bypass     = (i_cmd.key == oaht_pkg::EMPTY_KEY) ||
                        !(i_cmd.op inside {oaht_pkg::OP_QUERY, oaht_pkg::OP_REGISTER,
                                           oaht_pkg::OP_ERASE});
    assign slot_empty = (r_rd_key == oaht_pkg::EMPTY_KEY);
    assign slot_hit   = !slot_empty && (r_rd_key == r_cmd.key);
    assign probes_inc = r_probes + CW'(1);
    assign last_probe = (probes_inc == n_slots);
    // One slot always stays free.
    assign room       = ({1'b0, r_count} + (CW+1)'(1)) < {1'b0, n_slots};

    assign busy        = (r_state != oaht_pkg::ST_IDLE);
    assign o_cfg_ready = !busy || (r_state == oaht_pkg::ST_CLEAR);
    assign o_done      = r_done;
    assign o_result    = r_result;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            oaht_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(oaht_pkg::DEPTH - 1)) begin
                    n_state = oaht_pkg::ST_IDLE;
                end
            end
            oaht_pkg::ST_IDLE: begin
                if (start && !bypass) begin
                    n_state = oaht_pkg::ST_HASH;
                end
            end
            oaht_pkg::ST_HASH: begin
                if (r_fold_key == '0) begin
                    n_state = oaht_pkg::ST_READ;
                end
            end
            oaht_pkg::ST_READ: begin
                n_state = oaht_pkg::ST_CMP;
            end
            oaht_pkg::ST_CMP: begin
                if (slot_empty || slot_hit || last_probe) begin
                    n_state = oaht_pkg::ST_IDLE;
                end else begin
                    n_state = oaht_pkg::ST_READ;
                end
            end
            default: n_state = oaht_pkg::ST_CLEAR;
        endcase
    end

    // Datapath, memory writes and the result beat.
    always_comb begin
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_fold_key = r_fold_key;
        n_acc      = r_acc;
        n_addr     = r_addr;
        n_probes   = r_probes;
        n_done     = 1'b0;
        n_result   = r_result;
        key_we     = 1'b0;
        key_waddr  = r_addr;
        key_wdata  = oaht_pkg::EMPTY_KEY;
        val_we     = 1'b0;
        val_wdata  = '0;
        case (r_state)
            oaht_pkg::ST_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr_addr;
            end
            oaht_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd      = i_cmd;
                    n_fold_key = i_cmd.key;
                    n_acc      = '0;
                    if (bypass) begin
                        n_done              = 1'b1;
                        n_result.read_value = '0;
                        n_result.was_added  = 1'b0;
                        n_result.overflow   = 1'b0;
                        n_result.half_full  = r_count > (n_slots >> 1);
                    end
                end
            end
            oaht_pkg::ST_HASH: begin
                if (r_fold_key == '0) begin
                    n_addr   = r_acc;
                    n_probes = '0;
                end else begin
                    n_acc      = r_acc ^ AW'(r_fold_key & fold_mask);
                    n_fold_key = r_fold_key >> lg;
                end
            end
            oaht_pkg::ST_READ: begin
            end
            oaht_pkg::ST_CMP: begin
                n_result.read_value = '0;
                n_result.was_added  = 1'b0;
                n_result.overflow   = 1'b0;
                if (slot_empty || slot_hit || last_probe) begin
                    n_done = 1'b1;
                    case (r_cmd.op)
                        oaht_pkg::OP_QUERY: begin
                            if (slot_hit) begin
                                n_result.read_value = r_rd_val;
                            end else if (slot_empty) begin
                                val_we = 1'b1;
                            end
                        end
                        oaht_pkg::OP_REGISTER: begin
                            if (slot_hit) begin
                                val_we    = 1'b1;
                                val_wdata = r_cmd.value;
                            end else if (slot_empty && room) begin
                                key_we             = 1'b1;
                                key_wdata          = r_cmd.key;
                                val_we             = 1'b1;
                                val_wdata          = r_cmd.value;
                                n_count            = r_count + CW'(1);
                                n_result.was_added = 1'b1;
                            end else begin
                                n_result.overflow = 1'b1;
                            end
                        end
                        oaht_pkg::OP_ERASE: begin
                            // Erase leaves no tombstone and keeps the count.
                            if (slot_hit) begin
                                key_we = 1'b1;
                            end else if (slot_empty) begin
                                val_we = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_result.half_full = n_count > (n_slots >> 1);
                end else begin
                    n_probes = probes_inc;
                    n_addr   = AW'(r_addr + AW'(oaht_pkg::PROBE_STEP)) & slot_mask;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaht_pkg::ST_CLEAR;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_size_log2 <= oaht_pkg::SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
            if (r_state == oaht_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_size_log2 <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_result   <= n_result;
        r_fold_key <= n_fold_key;
        r_acc      <= n_acc;
        r_addr     <= n_addr;
        r_probes   <= n_probes;
    end

    // Key memory: one write port, registered read at the probe address.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[key_waddr] <= key_wdata;
        end
        r_rd_key <= mem_key[r_addr];
    end

    // Value memory: written only at the probe address.
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            mem_val[r_addr] <= val_wdata;
        end
        r_rd_val <= mem_val[r_addr];
    end

endmodule
